>>> rtl/sve_pkg.sv
// ----------------------------------------------------------------------------
// sve_pkg: shared types and constants for the signed varint byte encoder
// Holds the field widths, the small-value offset and the structs passed
// between the classifier, the byte shifter and the top level.
// ----------------------------------------------------------------------------
package sve_pkg;

	localparam int VALUE_W      = 64;
	localparam int BYTE_W       = 8;
	localparam int MAX_BYTES    = VALUE_W / BYTE_W;
	localparam int CNT_W        = 4;
	localparam int SMALL_LIMIT  = 120;
	localparam logic [BYTE_W-1:0] SMALL_OFFSET = 8'd8;

	// Item as resolved at load time: header byte, payload count, payload bits
	typedef struct packed {
		logic [BYTE_W-1:0]  hdr;
		logic [CNT_W-1:0]   cnt;
		logic [VALUE_W-1:0] mag;
	} load_t;

	// Byte offered by the shifter plus its sequencing status
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic [CNT_W-1:0]  cnt;
	} emit_t;

endpackage

>>> rtl/sve_classify.sv
// ----------------------------------------------------------------------------
// sve_classify: sorts an incoming value into the short or long encoding
// Works out sign, magnitude, small-value byte, byte count and header byte.
// ----------------------------------------------------------------------------
module sve_classify (
	input  logic [sve_pkg::VALUE_W-1:0] value_bits,
	input  logic                        is_signed,
	output sve_pkg::load_t              load
);
	import sve_pkg::*;

	logic                neg;
	logic [VALUE_W-1:0]  mag;
	logic                small_val;
	logic [BYTE_W-1:0]   small_byte;
	logic [BYTE_W-1:0]   low_byte;
	logic [CNT_W-1:0]    nbytes;
	logic [BYTE_W-1:0]   long_hdr;

	// Negative values are inverted; the range test then is the same for both
	assign neg       = is_signed & value_bits[VALUE_W-1];
	assign mag       = neg ? ~value_bits : value_bits;
	assign small_val = (mag[VALUE_W-1:7] == '0) && (mag[6:0] < 7'(SMALL_LIMIT));

	// Single-byte form: zero stays, others move away from zero by the offset
	assign low_byte = value_bits[BYTE_W-1:0];
	always_comb begin
		if (low_byte == '0) begin
			small_byte = '0;
		end else if (neg) begin
			small_byte = low_byte - SMALL_OFFSET;
		end else begin
			small_byte = low_byte + SMALL_OFFSET;
		end
	end

	// Byte count: one past the highest nonzero byte of the magnitude
	always_comb begin
		nbytes = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			if (mag[i*BYTE_W +: BYTE_W] != '0) begin
				nbytes = CNT_W'(i + 1);
			end
		end
	end

	// Header is the count, negated for negative values
	assign long_hdr = neg ? (BYTE_W'(0) - BYTE_W'(nbytes)) : BYTE_W'(nbytes);

	assign load.hdr = small_val ? small_byte : long_hdr;
	assign load.cnt = small_val ? '0 : nbytes;
	assign load.mag = mag;

endmodule

>>> rtl/sve_shifter.sv
// ----------------------------------------------------------------------------
// sve_shifter: byte-serial emitter
// Sends the header byte, then shifts the payload out one byte per cycle while
// take is high, least significant first, counting down the remaining bytes.
// ----------------------------------------------------------------------------
module sve_shifter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load_en,
	input  sve_pkg::load_t load,
	input  logic           take,
	output sve_pkg::emit_t emit
);
	import sve_pkg::*;

	logic                hdr_pend_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [BYTE_W-1:0]   hdr_q;
	logic [VALUE_W-1:0]  sh_q;
	logic                busy;
	logic                step;

	assign busy = hdr_pend_q || (cnt_q != '0);
	assign step = busy && take;

	// Control: header flag and payload countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pend_q <= 1'b0;
			cnt_q      <= '0;
		end else if (load_en) begin
			hdr_pend_q <= 1'b1;
			cnt_q      <= load.cnt;
		end else if (step) begin
			if (hdr_pend_q) begin
				hdr_pend_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Payload: header byte and the byte shift register
	always_ff @(posedge clk) begin
		if (load_en) begin
			hdr_q <= load.hdr;
			sh_q  <= load.mag;
		end else if (step && !hdr_pend_q) begin
			sh_q <= {BYTE_W'(0), sh_q[VALUE_W-1:BYTE_W]};
		end
	end

	// Offered byte
	assign emit.valid = busy;
	assign emit.data  = hdr_pend_q ? hdr_q : sh_q[BYTE_W-1:0];
	assign emit.last  = hdr_pend_q ? (cnt_q == '0) : (cnt_q == CNT_W'(1));
	assign emit.cnt   = cnt_q;

endmodule

>>> rtl/signed_varint_byte_encoder_top.sv
// ----------------------------------------------------------------------------
// signed_varint_byte_encoder_top: compact byte encoder for 64-bit integers
// Turns each value into one small byte, or a count header followed by the
// significant bytes of the (inverted, if negative) value.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_stall, value_bits,  | in (in_stall out)
//          | is_signed                        |
//  output  | out_valid, out_stall, out_byte,  | out (out_stall in)
//          | last_byte                        |
//
// An item is one output byte for a small value, or n + 1 for a long one
// (n = 1..8), so at most 9; the byte shifter emits one byte per cycle while
// the output takes it. The next item is taken in the cycle its predecessor's
// last byte moves into the output register. Reset clears the sequencer and
// output valid. A stalled output holds its byte and halts the shifter.
// ----------------------------------------------------------------------------
module signed_varint_byte_encoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sve_pkg::VALUE_W-1:0] value_bits,
	input  logic                        is_signed,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sve_pkg::BYTE_W-1:0]  out_byte,
	output logic                        last_byte
);
	import sve_pkg::*;

	load_t             load;
	emit_t             emit;
	logic              take;
	logic              accept;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;

	sve_classify u_classify (
		.value_bits (value_bits),
		.is_signed  (is_signed),
		.load       (load)
	);

	sve_shifter u_shifter (
		.clk     (clk),
		.arst_n  (arst_n),
		.load_en (accept),
		.load    (load),
		.take    (take),
		.emit    (emit)
	);

	// Output slot is free when empty or being drained
	assign take     = !out_valid_q || !out_stall;
	assign in_stall = emit.valid && !(take && emit.last);
	assign accept   = in_valid && !in_stall;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit.valid) begin
			out_byte_q <= emit.data;
			last_q     <= emit.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	// An accepted item always leaves the shifter with a byte to send
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> emit.valid)
		else $error("shifter idle after item accepted");

	// Payload count never exceeds the widest encoding
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		emit.cnt <= CNT_W'(MAX_BYTES))
		else $error("payload count out of range");

	// A delivered byte that is not last must have more bytes behind it
	a_more_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_byte) |-> emit.valid)
		else $error("item ended without last byte");

endmodule
